>>> sv/bds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_pkg: shared constants and helpers for the 2x2 box downsampler
// Holds the field widths, line buffer geometry, register map and the
// dimension clamp that turns a programmed size into a last index.
// ----------------------------------------------------------------------------
package bds_pkg;

    // Largest source width and height the block supports.
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // The line buffer holds one pair sum per two source columns.
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int SLOT_W     = $clog2(LINE_DEPTH);

    // Counter widths follow the largest dimensions.
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    // Payload and register widths.
    localparam int SAMPLE_W = 16;
    localparam int PAIR_W   = SAMPLE_W + 1;
    localparam int SUM_W    = SAMPLE_W + 2;
    localparam int DIM_W    = 13;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // Register index, taken from the word address bit.
    localparam logic REG_SOURCE_WIDTH  = 1'b0;
    localparam logic REG_SOURCE_HEIGHT = 1'b1;

    // Clamp a programmed dimension to 1..top and return the last index.
    function automatic logic [31:0] dim_last(input logic [DIM_W-1:0] v, input int top);
        logic [31:0] ext;
        logic [31:0] res;
        ext = {{(32 - DIM_W){1'b0}}, v};
        if (ext == 32'd0) begin
            res = 32'd0;
        end else if (ext > 32'(top)) begin
            res = 32'(top) - 32'd1;
        end else begin
            res = ext - 32'd1;
        end
        return res;
    endfunction

endpackage

>>> sv/bds_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered and holds
// its value in cycles without a read.
// ----------------------------------------------------------------------------
module bds_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/box_downsample_2x2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downsample_2x2: one level of a 2x2 box-filter mipmap
// Takes 16-bit samples in raster order and emits the truncated mean of each
// 2x2 block; partial blocks at an odd last column or row average only the
// samples that exist.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  ---------------------------
//  input     in         i_in_valid / o_in_stall   i_sample
//  output    out        o_out_valid / i_out_stall o_average, o_image_done
//  config    in         APB psel/penable/pready   paddr, pwdata, prdata
//
// One sample is accepted per cycle while o_in_stall is low. A result for
// a completed block passes the read stage, where the line buffer is read,
// and then the add and shift into the output register.
// Even rows store pair sums in a 2048-entry line buffer that odd rows read.
// Reset clears the counters and the pipeline; the line buffer is not
// cleared, since every entry is written before it is read.
// A stall on the output backs up through the pipeline to o_in_stall.
// ----------------------------------------------------------------------------
module box_downsample_2x2 (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Sample input
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [bds_pkg::SAMPLE_W-1:0] i_sample,
    // Result output
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [bds_pkg::SAMPLE_W-1:0] o_average,
    output logic                         o_image_done,
    // Configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bds_pkg::APB_AW-1:0]   paddr,
    input  logic [bds_pkg::APB_DW-1:0]   pwdata,
    output logic [bds_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    // Configuration registers and their derived last indexes.
    logic [bds_pkg::DIM_W-1:0] r_width;
    logic [bds_pkg::DIM_W-1:0] r_height;
    logic [bds_pkg::COL_W-1:0] r_width_last;
    logic [bds_pkg::ROW_W-1:0] r_height_last;

    // Position and held even-column sample.
    logic [bds_pkg::COL_W-1:0]    r_col;
    logic [bds_pkg::ROW_W-1:0]    r_row;
    logic [bds_pkg::SAMPLE_W-1:0] r_left;

    // Read stage, waiting on the line buffer.
    logic                       r_s1_valid;
    logic [bds_pkg::PAIR_W-1:0] r_s1_pair;
    logic                       r_s1_pair_shift;
    logic                       r_s1_odd_row;
    logic                       r_s1_done;

    // Output register.
    logic                         r_out_valid;
    logic [bds_pkg::SAMPLE_W-1:0] r_out_average;
    logic                         r_out_done;

    logic                         cfg_write;
    logic                         out_free;
    logic                         s1_free;
    logic                         in_accept;
    logic                         last_col;
    logic                         last_row;
    logic                         pair_done;
    logic                         line_we;
    logic                         emit;
    logic                         line_re;
    logic [bds_pkg::PAIR_W-1:0]   pair;
    logic                         pair_shift;
    logic [bds_pkg::SLOT_W-1:0]   slot;
    logic [bds_pkg::PAIR_W-1:0]   line_rdata;
    logic [bds_pkg::SUM_W-1:0]    sum;
    logic [1:0]                   shift;
    logic [bds_pkg::SUM_W-1:0]    shifted;
    logic [bds_pkg::COL_W-1:0]    n_col;
    logic [bds_pkg::ROW_W-1:0]    n_row;

    // APB: always ready, combinational read.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        unique case (paddr[2])
            bds_pkg::REG_SOURCE_WIDTH:  prdata = {{(bds_pkg::APB_DW - bds_pkg::DIM_W){1'b0}},
                                                  r_width};
            bds_pkg::REG_SOURCE_HEIGHT: prdata = {{(bds_pkg::APB_DW - bds_pkg::DIM_W){1'b0}},
                                                  r_height};
            default:                    prdata = '0;
        endcase
    end

    // Pipeline flow control.
    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign s1_free    = ~r_s1_valid | out_free;
    assign o_in_stall = ~s1_free;
    assign in_accept  = i_in_valid & s1_free;

    // Position decode for the incoming sample.
    assign last_col  = (r_col == r_width_last);
    assign last_row  = (r_row == r_height_last);
    assign slot      = r_col[bds_pkg::COL_W-1:1];
    assign pair_done = r_col[0] | last_col;

    // Horizontal pair: sum of two samples, or a lone last-column sample.
    always_comb begin
        if (r_col[0]) begin
            pair       = {1'b0, r_left} + {1'b0, i_sample};
            pair_shift = 1'b1;
        end else begin
            pair       = {1'b0, i_sample};
            pair_shift = 1'b0;
        end
    end

    // Even rows store pairs; odd rows and an odd last row produce results.
    assign line_we = in_accept & pair_done & ~r_row[0] & ~last_row;
    assign emit    = pair_done & (r_row[0] | last_row);
    assign line_re = in_accept & emit & r_row[0];

    // Next position, wrapping at the end of a row and of the image.
    always_comb begin
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end
    end

    bds_ram #(
        .WIDTH (bds_pkg::PAIR_W),
        .DEPTH (bds_pkg::LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (slot),
        .i_wdata (pair),
        .i_re    (line_re),
        .i_raddr (slot),
        .o_rdata (line_rdata)
    );

    // Configuration and position registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width       <= bds_pkg::DIM_W'(1);
            r_height      <= bds_pkg::DIM_W'(1);
            r_width_last  <= '0;
            r_height_last <= '0;
            r_col         <= '0;
            r_row         <= '0;
            r_left        <= '0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                bds_pkg::REG_SOURCE_WIDTH: begin
                    r_width      <= pwdata[bds_pkg::DIM_W-1:0];
                    r_width_last <= bds_pkg::COL_W'(bds_pkg::dim_last(
                        pwdata[bds_pkg::DIM_W-1:0], bds_pkg::MAX_WIDTH));
                end
                bds_pkg::REG_SOURCE_HEIGHT: begin
                    r_height      <= pwdata[bds_pkg::DIM_W-1:0];
                    r_height_last <= bds_pkg::ROW_W'(bds_pkg::dim_last(
                        pwdata[bds_pkg::DIM_W-1:0], bds_pkg::MAX_HEIGHT));
                end
                default: ;
            endcase
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else if (in_accept) begin
            r_col <= n_col;
            r_row <= n_row;
            if (!pair_done) begin
                r_left <= i_sample;
            end
        end
    end

    // Read stage: holds the pair while the line buffer answers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= in_accept & emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_pair       <= pair;
            r_s1_pair_shift <= pair_shift;
            r_s1_odd_row    <= r_row[0];
            r_s1_done       <= last_row & last_col;
        end
    end

    // Vertical add and divide by 1, 2 or 4.
    always_comb begin
        sum   = {1'b0, r_s1_pair};
        shift = {1'b0, r_s1_pair_shift};
        if (r_s1_odd_row) begin
            sum   = {1'b0, r_s1_pair} + {1'b0, line_rdata};
            shift = {1'b0, r_s1_pair_shift} + 2'd1;
        end
        shifted = sum >> shift;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_average <= shifted[bds_pkg::SAMPLE_W-1:0];
            r_out_done    <= r_s1_done;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_average    = r_out_average;
    assign o_image_done = r_out_done;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the 2x2 box downsampler
// Streams source samples into the block, predicts every averaged output
// sample from its own copy of the counters and line buffer, and compares
// each result field by field. Runs directed corner cases, oversized
// settings, back-pressure phases and random image sequences with idle gaps.
// ----------------------------------------------------------------------------
module tb;

    // Byte addresses of the two registers.
    localparam logic [bds_pkg::APB_AW-1:0] ADDR_SOURCE_WIDTH  =
        {bds_pkg::REG_SOURCE_WIDTH, 2'b00};
    localparam logic [bds_pkg::APB_AW-1:0] ADDR_SOURCE_HEIGHT =
        {bds_pkg::REG_SOURCE_HEIGHT, 2'b00};

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 300;
    localparam int WIDE_SAMPLES   = 240;
    localparam int TALL_SAMPLES   = 200;
    localparam int RANDOM_SAMPLES = 1270;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [bds_pkg::SAMPLE_W-1:0] average;
        logic                         image_done;
    } t_box_result;

    // Clock, reset and block ports.
    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_stall;
    logic [bds_pkg::SAMPLE_W-1:0] i_sample    = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [bds_pkg::SAMPLE_W-1:0] o_average;
    logic                         o_image_done;
    logic                         psel        = 1'b0;
    logic                         penable     = 1'b0;
    logic                         pwrite      = 1'b0;
    logic [bds_pkg::APB_AW-1:0]   paddr       = '0;
    logic [bds_pkg::APB_DW-1:0]   pwdata      = '0;
    logic [bds_pkg::APB_DW-1:0]   prdata;
    logic                         pready;

    // Predictor state: register copies, raster position and line buffer.
    logic [bds_pkg::DIM_W-1:0]    src_width  = bds_pkg::DIM_W'(1);
    logic [bds_pkg::DIM_W-1:0]    src_height = bds_pkg::DIM_W'(1);
    int                           col_pos    = 0;
    int                           row_pos    = 0;
    logic [bds_pkg::SAMPLE_W-1:0] held_left  = '0;
    logic [bds_pkg::PAIR_W-1:0]   pair_line [bds_pkg::LINE_DEPTH];
    t_box_result                  pending_averages [$];

    // Idling controls shared by the stimulus and the receiver.
    bit in_gaps_on    = 1'b0;
    bit out_stalls_on = 1'b0;
    bit out_quiet     = 1'b0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int stall_run     = 0;

    // Run statistics.
    int samples_sent    = 0;
    int results_seen    = 0;
    int reg_writes      = 0;
    int in_stall_cycles = 0;
    int mismatch_count  = 0;
    int quiet_cycles    = 0;

    box_downsample_2x2 uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_average    (o_average),
        .o_image_done (o_image_done),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A programmed size of zero means one; anything above the top is the top.
    function automatic int clamp_dim(input logic [bds_pkg::DIM_W-1:0] v, input int top);
        if (v == '0) return 1;
        if (int'(v) > top) return top;
        return int'(v);
    endfunction

    function automatic int image_samples();
        return clamp_dim(src_width, bds_pkg::MAX_WIDTH) *
               clamp_dim(src_height, bds_pkg::MAX_HEIGHT);
    endfunction

    // Advance the raster position by one sample and queue any finished block.
    function automatic void predict_block_average(input logic [bds_pkg::SAMPLE_W-1:0] s);
        int                         w;
        int                         h;
        int                         slot;
        int                         shift;
        bit                         last_col;
        bit                         last_row;
        bit                         pair_done;
        logic [bds_pkg::PAIR_W-1:0] pair;
        logic [bds_pkg::SUM_W-1:0]  sum;
        t_box_result                res;
        w         = clamp_dim(src_width, bds_pkg::MAX_WIDTH);
        h         = clamp_dim(src_height, bds_pkg::MAX_HEIGHT);
        slot      = (col_pos / 2) % bds_pkg::LINE_DEPTH;
        last_col  = (col_pos + 1 == w);
        last_row  = (row_pos + 1 == h);
        pair_done = 1'b1;
        shift     = 0;
        pair      = '0;

        // Horizontal pair: odd column closes it, an odd last column stands alone.
        if ((col_pos % 2) != 0) begin
            pair  = bds_pkg::PAIR_W'(held_left) + bds_pkg::PAIR_W'(s);
            shift = 1;
        end else if (last_col) begin
            pair = bds_pkg::PAIR_W'(s);
        end else begin
            held_left = s;
            pair_done = 1'b0;
        end

        // Even rows park the pair; odd rows and an odd last row emit.
        if (pair_done) begin
            if ((row_pos % 2) == 0 && !last_row) begin
                pair_line[slot] = pair;
            end else begin
                sum = bds_pkg::SUM_W'(pair);
                if ((row_pos % 2) != 0) begin
                    sum   = sum + bds_pkg::SUM_W'(pair_line[slot]);
                    shift = shift + 1;
                end
                res.average    = bds_pkg::SAMPLE_W'(sum >> shift);
                res.image_done = last_row && last_col;
                pending_averages.insert(pending_averages.size(), res);
            end
        end

        col_pos = col_pos + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = row_pos + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random samples with extra weight on the ends of the range.
    function automatic logic [bds_pkg::SAMPLE_W-1:0] any_sample();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return bds_pkg::SAMPLE_W'(16'hFFFF - $urandom_range(0, 15));
        return bds_pkg::SAMPLE_W'($urandom);
    endfunction

    // Offer one sample and hold it until the block takes the request.
    task automatic push_sample(input logic [bds_pkg::SAMPLE_W-1:0] s);
        int gap;
        i_in_valid <= 1'b1;
        i_sample   <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_block_average(s);
        samples_sent++;
        gap = in_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for every expected result, then let samples without a result
    // leave the pipeline with the output free.
    task automatic wait_drained();
        while (pending_averages.size() != 0) @(posedge i_clk);
        while (hold_left != 0) @(posedge i_clk);
        out_quiet = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        out_quiet = 1'b0;
    endtask

    // Write a register, read it back, and restart the predicted image.
    task automatic program_register(input logic [bds_pkg::APB_AW-1:0] addr,
                                    input logic [bds_pkg::APB_DW-1:0] data);
        logic [bds_pkg::APB_DW-1:0] want;
        want = bds_pkg::APB_DW'(data[bds_pkg::DIM_W-1:0]);

        // Write: setup then access.
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_SOURCE_WIDTH) src_width = data[bds_pkg::DIM_W-1:0];
        else src_height = data[bds_pkg::DIM_W-1:0];
        col_pos   = 0;
        row_pos   = 0;
        held_left = '0;
        reg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);

        // Read back.
        psel    <= 1'b1;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want) begin
            note_failure($sformatf("readback addr %0d: expected 0x%0h, got 0x%0h",
                                   addr, want, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_size(input logic [bds_pkg::APB_DW-1:0] w,
                            input logic [bds_pkg::APB_DW-1:0] h);
        end_burst();
        wait_drained();
        program_register(ADDR_SOURCE_WIDTH, w);
        program_register(ADDR_SOURCE_HEIGHT, h);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a counted long hold on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
            stall_run   <= 0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!out_stalls_on || out_quiet) begin
            i_out_stall <= 1'b0;
            stall_run   <= 0;
        end else if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else begin
            r = $urandom_range(99);
            if (r < 60) begin
                i_out_stall <= 1'b0;
                stall_run   <= $urandom_range(0, 4);
            end else if (r < 92) begin
                i_out_stall <= 1'b1;
                stall_run   <= $urandom_range(0, 2);
            end else if (r < 98) begin
                i_out_stall <= 1'b1;
                stall_run   <= $urandom_range(8, 20);
            end else begin
                i_out_stall <= 1'b1;
                stall_run   <= $urandom_range(30, 80);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_box_result want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall) in_stall_cycles++;

            // Count cycles in which neither channel moves a request.
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no request accepted for %0d cycles", quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end

            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (pending_averages.size() == 0) begin
                    note_failure($sformatf("unexpected result average=%0d image_done=%0b",
                                           o_average, o_image_done));
                end else begin
                    want = pending_averages.pop_front();
                    if (o_average !== want.average) begin
                        note_failure($sformatf("average: expected %0d, got %0d",
                                               want.average, o_average));
                    end
                    if (o_image_done !== want.image_done) begin
                        note_failure($sformatf("image_done: expected %0b, got %0b",
                                               want.image_done, o_image_done));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Full-scale samples through every block shape of an odd 3x3 image.
    task automatic test_sample_extremes();
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        set_size(3, 3);
        repeat (9) push_sample('1);
    endtask

    // Zero sizes act as one; two back-to-back 1x1 images wrap the counters.
    task automatic test_degenerate_sizes();
        set_size(0, 0);
        push_sample('0);
        push_sample('1);
    endtask

    // A register write in the middle of an image starts a new one.
    task automatic test_restart_mid_image();
        set_size(2, 2);
        push_sample(16'h1234);
        push_sample(16'hFFFF);
        push_sample(16'h0001);
        end_burst();
        wait_drained();
        program_register(ADDR_SOURCE_HEIGHT, 2);
        push_sample(16'h0000);
        push_sample(16'hFFFF);
        push_sample(16'hFFFF);
        push_sample(16'h0003);
    endtask

    // Widest row: a width above the maximum is taken as the maximum. The
    // single row is the last one, so every pair of its start is emitted.
    task automatic test_widest_row();
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        set_size(32'h0000_1FFF, 1);
        repeat (WIDE_SAMPLES) push_sample(any_sample());
    endtask

    // Tallest column: one sample per row, alternating stored and emitted rows.
    task automatic test_tallest_column();
        set_size(1, 32'h0000_1FFF);
        repeat (TALL_SAMPLES) push_sample(any_sample());
    endtask

    // Receiver holds off while the sender keeps going; then the sender waits
    // for every result before the next image.
    task automatic test_backpressure();
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b1;
        set_size(8, 6);
        hold_requests++;
        repeat (image_samples()) push_sample(any_sample());
        end_burst();
        wait_drained();
        in_gaps_on = 1'b1;
        repeat (image_samples()) push_sample(any_sample());
        hold_requests++;
        repeat (image_samples() / 2) push_sample(any_sample());
    endtask

    // Random sizes and samples; some images are cut short by a new setting.
    task automatic test_random_images();
        int                         target;
        int                         images;
        int                         n;
        bit                         cut;
        logic [bds_pkg::APB_DW-1:0] wdat;
        logic [bds_pkg::APB_DW-1:0] hdat;
        target = samples_sent + RANDOM_SAMPLES;
        while (samples_sent < target) begin
            wdat = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            hdat = ($urandom_range(99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 20);
            if ($urandom_range(19) == 0) wdat = 0;
            if ($urandom_range(19) == 0) hdat = 0;
            // Bits above the register width are dropped by the block.
            if ($urandom_range(3) == 0) wdat = wdat | ($urandom << bds_pkg::DIM_W);
            if ($urandom_range(3) == 0) hdat = hdat | ($urandom << bds_pkg::DIM_W);
            in_gaps_on    = ($urandom_range(3) != 0);
            out_stalls_on = ($urandom_range(3) != 0);
            set_size(wdat, hdat);

            images = $urandom_range(1, 3);
            for (int k = 0; k < images; k++) begin
                n   = image_samples();
                cut = ($urandom_range(6) == 0);
                if (cut) n = $urandom_range(1, n);
                // The last image stops where the sample budget runs out.
                if (n >= target - samples_sent) begin
                    n   = target - samples_sent;
                    cut = 1'b1;
                end
                repeat (n) push_sample(any_sample());
                if (cut) break;
                if ($urandom_range(9) == 0) begin
                    end_burst();
                    wait_drained();
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_sample_extremes();
        test_degenerate_sizes();
        test_restart_mid_image();
        test_backpressure();
        test_widest_row();
        test_tallest_column();
        test_random_images();

        end_burst();
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d samples, checked %0d averages, %0d register writes.",
                 samples_sent, results_seen, reg_writes);
        $display("Input held off %0d cycles; sizes from zero to above the maximum.",
                 in_stall_cycles);
        if (pending_averages.size() != 0) begin
            $display("ERROR: %0d expected averages never arrived", pending_averages.size());
        end
        if (mismatch_count == 0 && pending_averages.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Mismatches: %0d", mismatch_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
